// ===== rtl/xchacha20_stream_cipher_macros.svh =====
// ---------------------------------------------------------------------------
// XChaCha20 assertion macros
// Shorthand for concurrent checks used by the top level.
// ---------------------------------------------------------------------------
`ifndef XCHACHA20_STREAM_CIPHER_MACROS_SVH
`define XCHACHA20_STREAM_CIPHER_MACROS_SVH

// Implication checked every clock, off during reset.
`define XCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked every clock, off during reset.
`define XCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/xcc_pkg.sv =====
// ---------------------------------------------------------------------------
// XChaCha20 package
// Payload types, register indexes and cipher constants.
// ---------------------------------------------------------------------------
package xcc_pkg;

  typedef struct packed {
    logic [63:0] text_chunk;
    logic [3:0]  chunk_bytes;
    logic        final_chunk;
  } xcc_in_t;

  typedef struct packed {
    logic [63:0] cipher_chunk;
    logic [3:0]  out_bytes;
    logic        out_final;
  } xcc_out_t;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;
  localparam logic [2:0] REG_NONCE2 = 3'd6;
  localparam logic [2:0] REG_CTR    = 3'd7;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // controller -> datapath
  typedef struct packed {
    logic load_hchacha;
    logic load_chacha;
    logic round_step;
    logic save_subkey;
    logic save_keystream;
    logic take_chunk;
  } xcc_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // One quarter round on four words.
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] aa, bb, cc, dd;
    aa = a + b; dd = rotl(d ^ aa, 16);
    cc = c + dd; bb = rotl(b ^ cc, 12);
    aa = aa + bb; dd = rotl(dd ^ aa, 8);
    cc = cc + dd; bb = rotl(bb ^ cc, 7);
    qround = {aa, bb, cc, dd};
  endfunction

endpackage

// ===== rtl/xcc_datapath.sv =====
// ---------------------------------------------------------------------------
// XChaCha20 datapath
// State words, one half round per cycle, subkey and keystream storage, XOR.
// ---------------------------------------------------------------------------
module xcc_datapath import xcc_pkg::*; (
  input  logic           clk,
  input  xcc_cmd_t       cmd,
  input  logic [255:0]   key,
  input  logic [127:0]   nonce_lo,
  input  logic [63:0]    nonce_hi,
  input  logic [31:0]    start_counter,
  input  logic           diag,
  input  logic [2:0]     pos,
  input  xcc_in_t        in_item,
  output xcc_out_t       result
);

  logic [31:0] w_r [16];
  logic [31:0] init_r [16];
  logic [31:0] subkey_r [8];
  logic [31:0] ks_r [16];
  logic [31:0] blk_r;
  logic [31:0] w_nxt [16];
  logic [127:0] q0, q1, q2, q3;

  always_comb begin
    if (!diag) begin
      q0 = qround(w_r[0], w_r[4], w_r[8],  w_r[12]);
      q1 = qround(w_r[1], w_r[5], w_r[9],  w_r[13]);
      q2 = qround(w_r[2], w_r[6], w_r[10], w_r[14]);
      q3 = qround(w_r[3], w_r[7], w_r[11], w_r[15]);
      {w_nxt[0], w_nxt[4], w_nxt[8],  w_nxt[12]} = q0;
      {w_nxt[1], w_nxt[5], w_nxt[9],  w_nxt[13]} = q1;
      {w_nxt[2], w_nxt[6], w_nxt[10], w_nxt[14]} = q2;
      {w_nxt[3], w_nxt[7], w_nxt[11], w_nxt[15]} = q3;
    end else begin
      q0 = qround(w_r[0], w_r[5], w_r[10], w_r[15]);
      q1 = qround(w_r[1], w_r[6], w_r[11], w_r[12]);
      q2 = qround(w_r[2], w_r[7], w_r[8],  w_r[13]);
      q3 = qround(w_r[3], w_r[4], w_r[9],  w_r[14]);
      {w_nxt[0], w_nxt[5], w_nxt[10], w_nxt[15]} = q0;
      {w_nxt[1], w_nxt[6], w_nxt[11], w_nxt[12]} = q1;
      {w_nxt[2], w_nxt[7], w_nxt[8],  w_nxt[13]} = q2;
      {w_nxt[3], w_nxt[4], w_nxt[9],  w_nxt[14]} = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hchacha) begin
      w_r[0] <= SIGMA0; w_r[1] <= SIGMA1; w_r[2] <= SIGMA2; w_r[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) w_r[4 + i] <= key[32*i +: 32];
      for (int i = 0; i < 4; i++) w_r[12 + i] <= nonce_lo[32*i +: 32];
      blk_r <= start_counter;
    end else if (cmd.load_chacha) begin
      w_r[0] <= SIGMA0; w_r[1] <= SIGMA1; w_r[2] <= SIGMA2; w_r[3] <= SIGMA3;
      init_r[0] <= SIGMA0; init_r[1] <= SIGMA1; init_r[2] <= SIGMA2; init_r[3] <= SIGMA3;
      for (int i = 0; i < 8; i++) begin
        w_r[4 + i] <= subkey_r[i];
        init_r[4 + i] <= subkey_r[i];
      end
      w_r[12] <= blk_r;      init_r[12] <= blk_r;
      w_r[13] <= '0;         init_r[13] <= '0;
      w_r[14] <= nonce_hi[31:0];  init_r[14] <= nonce_hi[31:0];
      w_r[15] <= nonce_hi[63:32]; init_r[15] <= nonce_hi[63:32];
      blk_r <= blk_r + 32'd1;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
    end
    if (cmd.save_subkey) begin
      for (int i = 0; i < 4; i++) begin
        subkey_r[i] <= w_r[i];
        subkey_r[4 + i] <= w_r[12 + i];
      end
    end
    if (cmd.save_keystream) begin
      for (int i = 0; i < 16; i++) ks_r[i] <= w_r[i] + init_r[i];
    end
  end

  logic [3:0]  cnt;
  logic [63:0] ks, mask;

  always_comb begin
    cnt = in_item.chunk_bytes;
    if (cnt == 4'd0) cnt = 4'd1;
    if (cnt > 4'd8) cnt = 4'd8;
    ks = {ks_r[{pos, 1'b1}], ks_r[{pos, 1'b0}]};
    for (int i = 0; i < 8; i++) mask[8*i +: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_chunk) begin
      result.cipher_chunk <= (in_item.text_chunk ^ ks) & mask;
      result.out_bytes    <= cnt;
      result.out_final    <= in_item.final_chunk;
    end
  end

endmodule

// ===== rtl/xcc_ctrl.sv =====
// ---------------------------------------------------------------------------
// XChaCha20 controller
// Sequences subkey derivation, keystream blocks and chunk transfers.
// ---------------------------------------------------------------------------
module xcc_ctrl import xcc_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_final,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output xcc_cmd_t cmd,
  output logic     diag,
  output logic [2:0] pos
);

  localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RW = $clog2(HALF_ROUNDS + 1);

  typedef enum logic [2:0] {S_IDLE, S_HROUND, S_KLOAD, S_KROUND, S_READY} state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic          inmsg_r, inmsg_nxt;
  logic          ov_r, ov_nxt;
  logic          take;

  assign diag = rnd_r[0];
  assign pos = pos_r;
  assign out_valid = ov_r;
  assign in_ready = (state_r == S_READY) && (!ov_r || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    pos_nxt = pos_r;
    inmsg_nxt = inmsg_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!inmsg_r) begin
            cmd.load_hchacha = 1'b1;
            rnd_nxt = '0;
            pos_nxt = '0;
            inmsg_nxt = 1'b1;
            state_nxt = S_HROUND;
          end else if (pos_r == 3'd0) begin
            state_nxt = S_KLOAD;
          end else begin
            state_nxt = S_READY;
          end
        end
      end
      S_HROUND: begin
        if (rnd_r == RW'(HALF_ROUNDS)) begin
          cmd.save_subkey = 1'b1;
          state_nxt = S_KLOAD;
        end else begin
          cmd.round_step = 1'b1;
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      S_KLOAD: begin
        cmd.load_chacha = 1'b1;
        rnd_nxt = '0;
        state_nxt = S_KROUND;
      end
      S_KROUND: begin
        if (rnd_r == RW'(HALF_ROUNDS)) begin
          cmd.save_keystream = 1'b1;
          state_nxt = S_READY;
        end else begin
          cmd.round_step = 1'b1;
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      S_READY: begin
        if (take) begin
          cmd.take_chunk = 1'b1;
          ov_nxt = 1'b1;
          if (in_final) begin
            inmsg_nxt = 1'b0;
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= '0;
      pos_r <= '0;
      inmsg_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      pos_r <= pos_nxt;
      inmsg_r <= inmsg_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

// ===== rtl/xchacha20_stream_cipher.sv =====
// Flow: a chunk within a keystream block goes from idle to ready and is taken; a
// chunk that starts a block first loads the ChaCha state and runs DOUBLE_ROUNDS
// double rounds; a message's first chunk first derives the HChaCha subkey. One half
// round per cycle in four parallel quarter-round units.
// Reset: synchronous active-low; configuration registers zero, no message open.
// ---------------------------------------------------------------------------
// XChaCha20 stream cipher top level
// Configuration registers, controller and datapath.
// ---------------------------------------------------------------------------
`include "xchacha20_stream_cipher_macros.svh"
module xchacha20_stream_cipher import xcc_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  xcc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output xcc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_r [4];
  logic [63:0] nonce_r [3];
  logic [31:0] ctr_r;
  xcc_cmd_t    cmd;
  logic        diag;
  logic [2:0]  pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
      ctr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:   key_r[0] <= cfg_wdata;
        REG_KEY1:   key_r[1] <= cfg_wdata;
        REG_KEY2:   key_r[2] <= cfg_wdata;
        REG_KEY3:   key_r[3] <= cfg_wdata;
        REG_NONCE0: nonce_r[0] <= cfg_wdata;
        REG_NONCE1: nonce_r[1] <= cfg_wdata;
        REG_NONCE2: nonce_r[2] <= cfg_wdata;
        REG_CTR:    ctr_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  xcc_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_final(in_data.final_chunk),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .diag(diag), .pos(pos)
  );

  xcc_datapath u_dp (
    .clk(clk), .cmd(cmd),
    .key({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .nonce_lo({nonce_r[1], nonce_r[0]}), .nonce_hi(nonce_r[2]),
    .start_counter(ctr_r), .diag(diag), .pos(pos),
    .in_item(in_data), .result(out_data)
  );

`XCC_ASSERT_NEXT(a_take_valid, clk, rst_n, in_valid && in_ready, out_valid)
`XCC_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_hchacha, cmd.load_chacha, cmd.round_step}))
`XCC_ASSERT_IMP(a_no_take_in_round, clk, rst_n, cmd.round_step, !in_ready)

endmodule
